>>> rtl/vgip_pkg.sv
package vgip_pkg;

  localparam int SPEED_BITS      = 12;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_INDEX_BITS  = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_STEP_SHIFT  = 4;
  localparam int EXP_W           = 17;
  localparam int GAIN_W          = 16;
  localparam int ERR_W           = SPEED_BITS + 1;
  localparam int MUL_W           = 18;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int CFG_INDEX_W     = 3;

  localparam logic [31:0]         EXP_STEP_RATIO = 32'd4034748383;
  localparam logic [EXP_W-1:0]    EXP_ONE        = 17'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_MAX       = 16'hFFFF;
  localparam logic signed [15:0]  DRIVE_LIMIT    = 16'sd25600;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BASE_P_GAIN  = 3'd0,
    REG_EXTRA_P_GAIN = 3'd1,
    REG_P_SHAPE      = 3'd2,
    REG_I_SHAPE      = 3'd3,
    REG_MAX_I_GAIN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_P_SHAPE = 3'd0,
    MUL_I_SHAPE = 3'd1,
    MUL_EXTRA   = 3'd2,
    MUL_MAX_I   = 3'd3,
    MUL_P_DIFF  = 3'd4,
    MUL_I_SUM   = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] target_speed;
    logic signed [SPEED_BITS-1:0] measured_speed;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic [15:0]        p_gain_used;
    logic [15:0]        i_gain_used;
  } result_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     lat_ex_p;
    logic     lat_ex_i;
    logic     lat_pg;
    logic     lat_ig;
    logic     lat_t1;
    logic     lat_inc;
    logic     finish;
  } vgip_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } vgip_status_t;

  typedef logic [EXP_W-1:0] exp_table_t [EXP_TABLE_DEPTH];

  function automatic exp_table_t build_exp_table();
    exp_table_t  tab;
    logic [63:0] acc;
    tab[0] = EXP_ONE;
    for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
      acc    = 64'(tab[k-1]) * 64'(EXP_STEP_RATIO) + 64'h8000_0000;
      tab[k] = acc[32 +: EXP_W];
    end
    return tab;
  endfunction

  parameter exp_table_t EXP_TABLE = build_exp_table();

endpackage

>>> rtl/vgip_ctrl.sv
module vgip_ctrl import vgip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_stall,
  input  vgip_status_t status,
  output vgip_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_PS,
    ST_MUL_IS,
    ST_MUL_PX,
    ST_MUL_IX,
    ST_MUL_PD,
    ST_MUL_IS2,
    ST_SUM,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:    if (sample_valid) state <= ST_MUL_PS;
        ST_MUL_PS:  state <= ST_MUL_IS;
        ST_MUL_IS:  state <= ST_MUL_PX;
        ST_MUL_PX:  state <= ST_MUL_IX;
        ST_MUL_IX:  state <= ST_MUL_PD;
        ST_MUL_PD:  state <= ST_MUL_IS2;
        ST_MUL_IS2: state <= ST_SUM;
        ST_SUM:     state <= ST_FINISH;
        ST_FINISH:  if (!status.out_blocked) state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

  assign sample_stall = (state != ST_IDLE);

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_P_SHAPE;
    unique case (state)
      ST_IDLE:    cmd.load = sample_valid;
      ST_MUL_PS:  cmd.mul_sel = MUL_P_SHAPE;
      ST_MUL_IS: begin
        cmd.mul_sel  = MUL_I_SHAPE;
        cmd.lat_ex_p = 1'b1;
      end
      ST_MUL_PX: begin
        cmd.mul_sel  = MUL_EXTRA;
        cmd.lat_ex_i = 1'b1;
      end
      ST_MUL_IX: begin
        cmd.mul_sel = MUL_MAX_I;
        cmd.lat_pg  = 1'b1;
      end
      ST_MUL_PD: begin
        cmd.mul_sel = MUL_P_DIFF;
        cmd.lat_ig  = 1'b1;
      end
      ST_MUL_IS2: begin
        cmd.mul_sel = MUL_I_SUM;
        cmd.lat_t1  = 1'b1;
      end
      ST_SUM:     cmd.lat_inc = 1'b1;
      ST_FINISH:  cmd.finish = !status.out_blocked;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> rtl/vgip_datapath.sv
module vgip_datapath import vgip_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  vgip_cmd_t              cmd,
  output vgip_status_t           status,
  input  sample_t                sample,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int ARG_W = GAIN_W + SPEED_BITS;
  localparam int IDX_W = ARG_W - EXP_STEP_SHIFT;

  logic [GAIN_W-1:0] base_p_gain;
  logic [GAIN_W-1:0] extra_p_gain;
  logic [GAIN_W-1:0] p_shape;
  logic [GAIN_W-1:0] i_shape;
  logic [GAIN_W-1:0] max_i_gain;

  logic signed [ERR_W-1:0]  err;
  logic [SPEED_BITS-1:0]    mag;
  logic signed [ERR_W-1:0]  previous_error;
  logic signed [15:0]       drive_accumulator;
  logic [EXP_W-1:0]         ex_p;
  logic [EXP_W-1:0]         ex_i;
  logic [GAIN_W-1:0]        pg;
  logic [GAIN_W-1:0]        ig;
  logic signed [31:0]       t1;
  logic signed [32:0]       inc;
  logic signed [PROD_W-1:0] prod;

  logic signed [ERR_W-1:0]  err_in;
  logic signed [ERR_W:0]    err_diff;
  logic signed [ERR_W:0]    err_sum;
  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic [EXP_W-1:0]         exp_comp;
  logic [IDX_W-1:0]         exp_idx;
  logic [EXP_W-1:0]         exp_val;
  logic [GAIN_W:0]          pg_sum;
  logic signed [33:0]       twice_inc;
  logic signed [33:0]       drive_sum;
  logic signed [15:0]       drive_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_p_gain  <= 16'd256;
      extra_p_gain <= 16'd0;
      p_shape      <= 16'd256;
      i_shape      <= 16'd256;
      max_i_gain   <= 16'd0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_BASE_P_GAIN:  base_p_gain  <= cfg_data;
        REG_EXTRA_P_GAIN: extra_p_gain <= cfg_data;
        REG_P_SHAPE:      p_shape      <= cfg_data;
        REG_I_SHAPE:      i_shape      <= cfg_data;
        REG_MAX_I_GAIN:   max_i_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign err_in   = ERR_W'(sample.target_speed) - ERR_W'(sample.measured_speed);
  assign err_diff = (ERR_W + 1)'(err) - (ERR_W + 1)'(previous_error);
  assign err_sum  = (ERR_W + 1)'(err) + (ERR_W + 1)'(previous_error);
  assign exp_comp = EXP_ONE - ex_p;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_sel)
      MUL_P_SHAPE: begin
        op_a = MUL_W'(p_shape);
        op_b = MUL_W'(mag);
      end
      MUL_I_SHAPE: begin
        op_a = MUL_W'(i_shape);
        op_b = MUL_W'(mag);
      end
      MUL_EXTRA: begin
        op_a = MUL_W'(extra_p_gain);
        op_b = MUL_W'(exp_comp);
      end
      MUL_MAX_I: begin
        op_a = MUL_W'(max_i_gain);
        op_b = MUL_W'(ex_i);
      end
      MUL_P_DIFF: begin
        op_a = MUL_W'(pg);
        op_b = MUL_W'(err_diff);
      end
      MUL_I_SUM: begin
        op_a = MUL_W'(ig);
        op_b = MUL_W'(err_sum);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Arguments past the end of the table give an exponential of zero.
  assign exp_idx = prod[ARG_W-1:EXP_STEP_SHIFT];
  assign exp_val = (exp_idx < IDX_W'(EXP_TABLE_DEPTH)) ?
                   EXP_TABLE[exp_idx[EXP_INDEX_BITS-1:0]] : '0;

  assign pg_sum    = (GAIN_W + 1)'(base_p_gain) + (GAIN_W + 1)'(prod[31:16]);
  assign twice_inc = {t1[31], t1, 1'b0} + 34'($signed(prod[31:0]));
  assign drive_sum = 34'(drive_accumulator) + 34'(inc);

  always_comb begin
    priority if (drive_sum > 34'(DRIVE_LIMIT)) begin
      drive_next = DRIVE_LIMIT;
    end else if (drive_sum < -34'(DRIVE_LIMIT)) begin
      drive_next = -DRIVE_LIMIT;
    end else begin
      drive_next = drive_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.load) begin
      err <= err_in;
      mag <= err_in[ERR_W-1] ? SPEED_BITS'(-err_in) : SPEED_BITS'(err_in);
    end
    if (cmd.lat_ex_p) ex_p <= exp_val;
    if (cmd.lat_ex_i) ex_i <= exp_val;
    if (cmd.lat_pg)   pg <= pg_sum[GAIN_W] ? GAIN_MAX : pg_sum[GAIN_W-1:0];
    if (cmd.lat_ig)   ig <= prod[31:16];
    if (cmd.lat_t1)   t1 <= prod[31:0];
    if (cmd.lat_inc)  inc <= twice_inc[33:1];
    if (cmd.finish) begin
      result.drive       <= drive_next;
      result.p_gain_used <= pg;
      result.i_gain_used <= ig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error    <= '0;
      drive_accumulator <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (cmd.finish) begin
        previous_error    <= err;
        drive_accumulator <= drive_next;
        result_valid      <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.out_blocked = result_valid && result_stall;

endmodule

>>> rtl/variable_gain_incremental_pi_unit.sv
// Incremental PI speed controller whose gains follow the size of the speed error.
// Each sample beat gives a setpoint and a measured speed; one result beat returns
// the new clamped drive (Q8.8, -100 to +100 percent) with the P and I gains used.
// The block takes no new sample until it is through with the last one: six
// products pass in turn through a single shared 18x18 multiplier, then the
// increment is summed and the result clamped and registered. A finished result
// waits in the output register without holding up the next sample until that
// sample's own result is ready. The user must write gain registers through the
// configuration port only while no sample is in progress; this is not enforced.
module variable_gain_incremental_pi_unit import vgip_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data
);

  vgip_cmd_t    cmd;
  vgip_status_t status;

  vgip_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  vgip_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample           (sample),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
  );

`ifndef SYNTHESIS
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($signed(result.drive) <= DRIVE_LIMIT &&
                      $signed(result.drive) >= -DRIVE_LIMIT))
    else $error("drive outside the clamp range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(result_valid && result_stall))
    else $error("stalled result overwritten");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> !$rose(result_valid))
    else $error("result appeared right after sample acceptance");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> ##7 sample_stall)
    else $error("sample accepted before previous one finished");
`endif

endmodule
